// ===== hdl/mbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

   localparam int REG_BITS  = 48;
   localparam int ITER_BITS = 16;
   localparam int IDX_BITS  = 3;

   // configuration register indexes
   localparam logic [IDX_BITS-1:0] CSR_RE_MIN   = 3'd0;
   localparam logic [IDX_BITS-1:0] CSR_RE_STEP  = 3'd1;
   localparam logic [IDX_BITS-1:0] CSR_IM_MIN   = 3'd2;
   localparam logic [IDX_BITS-1:0] CSR_IM_STEP  = 3'd3;
   localparam logic [IDX_BITS-1:0] CSR_MAX_ITER = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD,
      ST_MUL,
      ST_ITER,
      ST_DONE
   } state_type;

   // control handed from the sequencer to the multiply chain
   typedef struct packed {
      logic start;   // load z = 0 and begin a new pixel
      logic step;    // advance the chain by one digit
   } chain_ctl_type;

endpackage

// ===== hdl/mbe_mul_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_mul_cell
// One cell of the serial multiply chain: accumulates one signed partial
// product per digit of the multiplier into its left-shifted running sum.
// ----------------------------------------------------------------------------
module mbe_mul_cell #(
   parameter int A_BITS = 48,
   parameter int D_BITS = 16,
   parameter int P_BITS = 96
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     clr,
   input  logic signed [A_BITS-1:0] a,
   input  logic        [D_BITS-1:0] digit,
   input  logic                     top_digit,
   output logic signed [P_BITS-1:0] acc
);
   logic signed [P_BITS-1:0] acc_ff;
   logic signed [P_BITS-1:0] acc_in;
   logic signed [A_BITS+D_BITS:0] part;

   always_comb begin
      // top digit carries the sign of the multiplier
      if (top_digit) begin
         part = a * $signed({digit[D_BITS-1], digit});
      end else begin
         part = a * $signed({1'b0, digit});
      end
      acc_in = clr ? P_BITS'(part) : (acc_ff <<< D_BITS) + P_BITS'(part);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
endmodule

// ===== hdl/mbe_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_core
// Iteration datapath: three multiply cells work the digits of zr and zi from
// the top down, one digit a cycle. After the products of z the next z is
// formed; after the squares of the new z it is tested.
// ----------------------------------------------------------------------------
module mbe_core #(
   parameter int FRAC_BITS = 44
) (
   input  logic                          clock,
   input  mbe_pkg::chain_ctl_type        ctl,
   input  logic                          iter_end,
   input  logic                          sq_phase,
   input  logic [2:0]                    digit_sel,
   input  logic signed [FRAC_BITS+3:0]   cr,
   input  logic signed [FRAC_BITS+3:0]   ci,
   output logic                          escaped
);
   localparam int W      = FRAC_BITS + 4;
   localparam int DB     = 16;
   localparam int ND     = (W + DB - 1) / DB;
   localparam int XW     = ND * DB;
   localparam int PW     = 2 * XW + 4;

   logic signed [W-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [XW-1:0] zr_x, zi_x;
   logic [DB-1:0] dr, di;
   logic top;
   logic signed [PW-1:0] p_rr, p_ii, p_ri;
   logic signed [PW-1:0] sum_r, sum_i, mag2, thr;
   logic signed [PW-1:0] shr_r, shr_i;
   logic signed [W-1:0] max_w, min_w;

   assign zr_x = XW'(zr_ff);
   assign zi_x = XW'(zi_ff);
   assign dr   = zr_x[digit_sel*DB +: DB];
   assign di   = zi_x[digit_sel*DB +: DB];
   assign top  = (32'(digit_sel) == ND - 1);

   // first cell squares zr, second squares zi, third forms zi*zr (zr*zr in the squaring phase)
   mbe_mul_cell #(.A_BITS(W), .D_BITS(DB), .P_BITS(PW)) u_rr (
      .clock(clock), .en(ctl.step), .clr(top), .a(zr_ff), .digit(dr),
      .top_digit(top), .acc(p_rr));
   mbe_mul_cell #(.A_BITS(W), .D_BITS(DB), .P_BITS(PW)) u_ii (
      .clock(clock), .en(ctl.step), .clr(top), .a(zi_ff), .digit(di),
      .top_digit(top), .acc(p_ii));
   mbe_mul_cell #(.A_BITS(W), .D_BITS(DB), .P_BITS(PW)) u_ri (
      .clock(clock), .en(ctl.step), .clr(top), .a(sq_phase ? zr_ff : zi_ff),
      .digit(dr), .top_digit(top), .acc(p_ri));

   assign max_w = {1'b0, {(W-1){1'b1}}};
   assign min_w = {1'b1, {(W-1){1'b0}}};
   assign thr   = PW'(1) <<< (2 * FRAC_BITS + 2);

   always_comb begin
      sum_r = p_rr - p_ii + (PW'(cr) <<< FRAC_BITS);
      sum_i = (p_ri <<< 1) + (PW'(ci) <<< FRAC_BITS);
      shr_r = sum_r >>> FRAC_BITS;
      shr_i = sum_i >>> FRAC_BITS;
      if (shr_r > PW'(max_w))      zr_in = max_w;
      else if (shr_r < PW'(min_w)) zr_in = min_w;
      else                         zr_in = W'(shr_r);
      if (shr_i > PW'(max_w))      zi_in = max_w;
      else if (shr_i < PW'(min_w)) zi_in = min_w;
      else                         zi_in = W'(shr_i);
      // in the squaring phase the cells hold zr^2 and zi^2 of the new z
      mag2    = p_rr + p_ii;
      escaped = mag2 > thr;
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         zr_ff <= '0;
         zi_ff <= '0;
      end else if (iter_end) begin
         zr_ff <= zr_in;
         zi_ff <= zi_in;
      end
   end
endmodule

// ===== hdl/mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time engine: one pixel in, its Mandelbrot iteration count out.
// ----------------------------------------------------------------------------
//  channel  | direction | ports
//  req      | in        | req_valid/req_ready, req_col, req_row
//  rsp      | out       | rsp_valid/rsp_ready, rsp_escape_count, rsp_col_out, rsp_row_out
//  csr      | in        | csr_valid/csr_ready, csr_index, csr_data
//
// One pixel at a time. Each iteration runs the multiply chain over the ND = 3
// digits of 16 bits (Q4.44) for the products of z, forms the new z, runs the
// chain over the digits again to square the new z, and makes the escape test.
// After acceptance c is formed, the iterations run (none with a zero limit)
// and the result is loaded, so the escape count sets the wait for rsp_valid.
// Reset is synchronous and restores the default view; the result register
// holds its item while rsp_ready is low and no new pixel is taken meanwhile;
// req_ready returns in the cycle after the result is taken.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
   parameter int FRAC_BITS  = 44,
   parameter int COORD_BITS = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_col,
   input  logic [COORD_BITS-1:0] req_row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_escape_count,
   output logic [COORD_BITS-1:0] rsp_col_out,
   output logic [COORD_BITS-1:0] rsp_row_out,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [47:0]           csr_data
);
   localparam int W  = FRAC_BITS + 4;
   localparam int RB = mbe_pkg::REG_BITS;
   localparam int ND = (W + 15) / 16;
   localparam int PB = RB + COORD_BITS + 1;
   localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

   mbe_pkg::state_type state_ff, state_in;
   mbe_pkg::chain_ctl_type ctl;

   logic signed [RB-1:0] re_min_ff, re_step_ff, im_min_ff, im_step_ff;
   logic [15:0] max_iter_ff;
   logic [COORD_BITS-1:0] col_ff, row_ff;
   logic signed [PB-1:0] pr_ff, pi_ff;
   logic signed [W-1:0] cr_ff, ci_ff, cr_in, ci_in;
   logic signed [PB+1:0] sr, si;
   logic [15:0] iter_ff, iter_in;
   logic [2:0] dig_ff, dig_in;
   logic sq_ff, sq_in;
   logic rsp_valid_ff;
   logic [15:0] cnt_ff, cnt_in;
   logic iter_end, escaped, load_rsp;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         re_min_ff   <= -48'sd35184372088832;
         re_step_ff  <= '0;
         im_min_ff   <= -48'sd26388279066624;
         im_step_ff  <= '0;
         max_iter_ff <= 16'd1000;
      end else if (csr_valid) begin
         case (csr_index)
            mbe_pkg::CSR_RE_MIN:   re_min_ff   <= csr_data;
            mbe_pkg::CSR_RE_STEP:  re_step_ff  <= csr_data;
            mbe_pkg::CSR_IM_MIN:   im_min_ff   <= csr_data;
            mbe_pkg::CSR_IM_STEP:  im_step_ff  <= csr_data;
            mbe_pkg::CSR_MAX_ITER: max_iter_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // coordinate: the product fits PB bits, so only the sum needs clamping
   always_comb begin
      sr = (PB+2)'(re_min_ff) + (PB+2)'(pr_ff);
      si = (PB+2)'(im_min_ff) + (PB+2)'(pi_ff);
      if (sr > (PB+2)'(MAX_W))      cr_in = MAX_W;
      else if (sr < (PB+2)'(MIN_W)) cr_in = MIN_W;
      else                          cr_in = W'(sr);
      if (si > (PB+2)'(MAX_W))      ci_in = MAX_W;
      else if (si < (PB+2)'(MIN_W)) ci_in = MIN_W;
      else                          ci_in = W'(si);
   end

   mbe_core #(.FRAC_BITS(FRAC_BITS)) u_core (
      .clock(clock), .ctl(ctl), .iter_end(iter_end), .sq_phase(sq_ff),
      .digit_sel(dig_ff), .cr(cr_ff), .ci(ci_ff), .escaped(escaped));

   // sequencer
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      iter_in   = iter_ff;
      dig_in    = dig_ff;
      sq_in     = sq_ff;
      cnt_in    = cnt_ff;
      iter_end  = 1'b0;
      load_rsp  = 1'b0;
      req_ready = (state_ff == mbe_pkg::ST_IDLE) && !rsp_valid_ff;
      case (state_ff)
         mbe_pkg::ST_IDLE: begin
            if (req_valid && req_ready) state_in = mbe_pkg::ST_COORD;
         end
         mbe_pkg::ST_COORD: begin
            ctl.start = 1'b1;
            iter_in   = '0;
            dig_in    = 3'(ND - 1);
            sq_in     = 1'b0;
            if (max_iter_ff == '0) begin
               cnt_in   = '0;
               state_in = mbe_pkg::ST_DONE;
            end else begin
               state_in = mbe_pkg::ST_MUL;
            end
         end
         mbe_pkg::ST_MUL: begin
            ctl.step = 1'b1;
            if (dig_ff == '0) begin
               dig_in   = 3'(ND - 1);
               state_in = mbe_pkg::ST_ITER;
            end else begin
               dig_in = dig_ff - 3'd1;
            end
         end
         mbe_pkg::ST_ITER: begin
            if (!sq_ff) begin
               // products of old z ready: take new z, then square it
               iter_end = 1'b1;
               sq_in    = 1'b1;
               state_in = mbe_pkg::ST_MUL;
            end else if (escaped) begin
               cnt_in   = iter_ff;
               state_in = mbe_pkg::ST_DONE;
            end else if (iter_ff + 16'd1 == max_iter_ff) begin
               cnt_in   = max_iter_ff;
               state_in = mbe_pkg::ST_DONE;
            end else begin
               iter_in  = iter_ff + 16'd1;
               sq_in    = 1'b0;
               state_in = mbe_pkg::ST_MUL;
            end
         end
         mbe_pkg::ST_DONE: begin
            load_rsp = 1'b1;
            state_in = mbe_pkg::ST_IDLE;
         end
         default: state_in = mbe_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp)             rsp_valid_ff <= 1'b1;
         else if (rsp_ready)       rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      dig_ff  <= dig_in;
      sq_ff   <= sq_in;
      cnt_ff  <= cnt_in;
      if (req_valid && req_ready) begin
         col_ff <= req_col;
         row_ff <= req_row;
         pr_ff  <= $signed({1'b0, req_col}) * re_step_ff;
         pi_ff  <= $signed({1'b0, req_row}) * im_step_ff;
      end
      if (state_ff == mbe_pkg::ST_COORD) begin
         cr_ff <= cr_in;
         ci_ff <= ci_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = cnt_ff;
   assign rsp_col_out      = col_ff;
   assign rsp_row_out      = row_ff;
endmodule

// ===== hdl/mbe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks on the escape-time engine.
// ----------------------------------------------------------------------------
module mbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_escape_count
);
   // one pixel in flight: no request taken while a result waits
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with result pending");

   // a taken request cannot produce a result in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");

   // a stalled result holds its count
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_escape_count))
      else $error("stalled result changed");
endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_escape_count(rsp_escape_count));

// ===== bench/escape_count_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_count_checker
// Watches the pixel, result and register channels of the escape-time block,
// works out the escape count of every accepted pixel and compares it with
// the result that comes back.
// ----------------------------------------------------------------------------
module escape_count_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [12:0] req_col,
   input  logic [12:0] req_row,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_escape_count,
   input  logic [12:0] rsp_col_out,
   input  logic [12:0] rsp_row_out,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data,
   output int          fail_count,
   output int          pending_pixels,
   output int          checked_pixels
);

   localparam int FRAC = 44;

   typedef struct {
      logic [15:0] count;
      logic [12:0] col;
      logic [12:0] row;
   } pixel_result_type;

   pixel_result_type   pixel_results_due[$];
   logic signed [47:0] view_re_min, view_re_step, view_im_min, view_im_step;
   logic [15:0]        view_max_iter;

   function automatic logic signed [127:0] clamp_word(logic signed [127:0] x);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< 47) - 1;
      lo = -(128'sd1 <<< 47);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function automatic logic signed [127:0] point_coord(logic signed [47:0] base,
                                                       logic signed [47:0] stride,
                                                       logic [12:0] idx);
      logic signed [127:0] p;
      p = $signed({115'd0, idx}) * 128'(stride);
      return clamp_word(128'(base) + p);
   endfunction

   function automatic logic [15:0] escape_count_of(logic [12:0] col, logic [12:0] row);
      logic signed [127:0] cr, ci, zr, zi, nr, ni, mag2, limit;
      logic [15:0] n;
      cr = point_coord(view_re_min, view_re_step, col);
      ci = point_coord(view_im_min, view_im_step, row);
      zr = 0;
      zi = 0;
      limit = 128'sd1 <<< (2 * FRAC + 2);
      for (int i = 0; i < view_max_iter; i++) begin
         nr = clamp_word((zr * zr - zi * zi + (cr <<< FRAC)) >>> FRAC);
         ni = clamp_word((2 * zr * zi + (ci <<< FRAC)) >>> FRAC);
         zr = nr;
         zi = ni;
         mag2 = zr * zr + zi * zi;
         if (mag2 > limit) return 16'(i);
      end
      n = view_max_iter;
      return n;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         view_re_min   <= -48'sd35184372088832;
         view_re_step  <= '0;
         view_im_min   <= -48'sd26388279066624;
         view_im_step  <= '0;
         view_max_iter <= 16'd1000;
         fail_count    <= 0;
         checked_pixels <= 0;
         pixel_results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mbe_pkg::CSR_RE_MIN:   view_re_min   <= csr_data;
               mbe_pkg::CSR_RE_STEP:  view_re_step  <= csr_data;
               mbe_pkg::CSR_IM_MIN:   view_im_min   <= csr_data;
               mbe_pkg::CSR_IM_STEP:  view_im_step  <= csr_data;
               mbe_pkg::CSR_MAX_ITER: view_max_iter <= csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want.count = escape_count_of(req_col, req_row);
            want.col   = req_col;
            want.row   = req_row;
            pixel_results_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            checked_pixels <= checked_pixels + 1;
            if (pixel_results_due.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected result count=%0d col=%0d row=%0d",
                           rsp_escape_count, rsp_col_out, rsp_row_out);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_results_due.pop_front();
               if (want.count !== rsp_escape_count || want.col !== rsp_col_out ||
                   want.row !== rsp_row_out) begin
                  if (fail_count < 10)
                     $display("ERROR: expected count=%0d col=%0d row=%0d, got %0d %0d %0d",
                              want.count, want.col, want.row,
                              rsp_escape_count, rsp_col_out, rsp_row_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_pixels <= pixel_results_due.size();
   end

endmodule

// ===== bench/tb_mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time
// Drives pixels and view settings into the escape-time block with random
// idling on both channels; the checker beside it predicts every count.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;

   localparam longint ONE       = 64'd1 << 44;
   localparam int     IDLE_LIMIT = 50000;

   logic        clock, reset;
   logic        req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   logic [12:0] req_col, req_row, rsp_col_out, rsp_row_out;
   logic [15:0] rsp_escape_count;
   logic [2:0]  csr_index;
   logic [47:0] csr_data;
   int          fail_count, pending_pixels, checked_pixels;
   int          pixels_sent, idle_cycles, views_set;
   logic        long_hold_done;

   mandelbrot_escape_time dut (.*);

   escape_count_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // short gaps mostly, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random stalls, plus one long hold-off once traffic is going
   initial begin
      int hold;
      rsp_ready = 1'b0;
      long_hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_hold_done && pixels_sent >= 120) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(negedge clock);
            long_hold_done = 1'b1;
         end
         hold = gap_len();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   // watchdog: give up when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // offer one pixel, hold it until taken; called at a falling edge
   task automatic send_pixel(input logic [12:0] col, input logic [12:0] row);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_col   <= col;
      req_row   <= row;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
      @(negedge clock);
   endtask

   // drop valid, wait for every result, then let the engine settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_view(input longint rmin, input longint rstep, input longint imin,
                           input longint istep, input logic [15:0] iters);
      drain();
      write_reg(mbe_pkg::CSR_RE_MIN, rmin[47:0]);
      write_reg(mbe_pkg::CSR_RE_STEP, rstep[47:0]);
      write_reg(mbe_pkg::CSR_IM_MIN, imin[47:0]);
      write_reg(mbe_pkg::CSR_IM_STEP, istep[47:0]);
      write_reg(mbe_pkg::CSR_MAX_ITER, {32'd0, iters});
      views_set++;
   endtask

   function automatic longint rand48();
      return longint'({$urandom(), $urandom()} << 16) >>> 16;
   endfunction

   initial begin
      longint base_re, base_im, span;
      logic [15:0] iters;
      reset = 1'b1;
      req_valid = 1'b0;
      req_col = '0;
      req_row = '0;
      csr_valid = 1'b0;
      csr_index = mbe_pkg::CSR_RE_MIN;
      csr_data = '0;
      pixels_sent = 0;
      views_set = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default view: steps are zero, so every pixel lands on the same point
      send_pixel(13'd0, 13'd0);
      send_pixel(13'h1fff, 13'h1fff);
      send_pixel(13'h1fff, 13'd0);

      // origin never escapes: the full default limit runs out
      set_view(0, 0, 0, 0, 16'd1000);
      send_pixel(13'd5, 13'd7);

      // extreme registers: coordinates saturate, one iteration only
      set_view(64'sh7fff_ffff_ffff, 64'sh7fff_ffff_ffff,
               -(64'sd1 <<< 47), -(64'sd1 <<< 47), 16'd1);
      send_pixel(13'd0, 13'd0);
      send_pixel(13'h1fff, 13'h1fff);
      send_pixel(13'd1, 13'h1fff);
      send_pixel(13'h1fff, 13'd1);

      // largest limit on points well outside the set
      set_view(5 * ONE / 2, ONE / 4096, -ONE, ONE / 4096, 16'hffff);
      send_pixel(13'd0, 13'd0);
      send_pixel(13'h1fff, 13'h0aaa);
      send_pixel(13'h1555, 13'h1fff);

      // classic full view, shallow limit
      set_view(-2 * ONE, 3 * ONE / 8191, -3 * ONE / 2, 3 * ONE / 8191, 16'd24);
      for (int i = 0; i < 10; i++)
         send_pixel(13'(i * 900), 13'(8191 - i * 900));

      // random phases: mostly sensible views, one with raw register noise
      for (int phase = 0; phase < 6; phase++) begin
         span = 3 * ONE / 8191;
         base_re = -2 * ONE + longint'($urandom_range(0, 1 << 20)) * 64;
         base_im = -3 * ONE / 2 + longint'($urandom_range(0, 1 << 20)) * 64;
         iters = 16'($urandom_range(2, 48));
         case (phase)
            1: set_view(-3 * ONE / 4, span / 64, ONE / 16, span / 64, 16'd64);
            3: set_view(rand48(), rand48(), rand48(), rand48(), 16'($urandom_range(1, 32)));
            5: set_view(base_re, -span, base_im, -span, iters);
            default: set_view(base_re, span, base_im, span, iters);
         endcase
         for (int k = 0; k < 100; k++)
            send_pixel(13'($urandom()), 13'($urandom()));
         // let the pipe run dry once with no config change
         if (phase == 2) drain();
      end

      drain();
      $display("Summary: %0d pixels sent, %0d results checked across %0d views",
               pixels_sent, checked_pixels, views_set);
      $display("Covered saturated coordinates, limits 1 to 65535 and a long result stall");
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
